// File: hdl/tcs_pkg.sv
// Shared types and constants for the text console scrollback block.
package tcs_pkg;
    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;

    localparam logic [1:0] OP_PUT  = 2'd0;
    localparam logic [1:0] OP_UP   = 2'd1;
    localparam logic [1:0] OP_DOWN = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    localparam logic [7:0] CH_NL  = 8'd10;
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam logic [15:0] BLANK_CELL = 16'h0720;

    localparam logic [1:0] REG_COLOR   = 2'd0;
    localparam logic [1:0] REG_GFX     = 2'd1;
    localparam logic [1:0] REG_STEP    = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } in_item_t;

    typedef struct packed {
        logic [15:0] cell_res;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [9:0]  view_offset;
        logic        ignored;
    } out_item_t;
endpackage

// File: hdl/tcs_if.sv
// Valid/ready channel interfaces for input and result items.
interface tcs_in_if;
    logic               valid;
    logic               ready;
    tcs_pkg::in_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcs_out_if;
    logic               valid;
    logic               ready;
    tcs_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/tcs_ram.sv
// Generic single-port RAM with registered read.
module tcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// File: hdl/text_console_scrollback.sv
// Text console with scrollback ring: top level and sequencer.
// Reset: a clearing pass blanks all RING_LINES*SCREEN_COLS cells, one per cycle (16000 at default).
// Steps: a read passes S_RD1, S_RD2 and S_OUT; scroll and backspace go straight to S_OUT;
// a printable character writes one cell in S_WRITE; a newline blanks the next line in S_NL,
// one cell per cycle; a tab writes up to 4 spaces in S_WRITE; a column wrap adds an S_NL pass.
// Throughput: one item at a time; the next transfer is taken the cycle after the result leaves.
module text_console_scrollback #(
    parameter int RING_LINES  = 200
) (
    input  logic       clk,
    input  logic       rst_n,
    tcs_in_if.sink     in_ch,
    tcs_out_if.source  out_ch,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    localparam int SCREEN_COLS = tcs_pkg::SCREEN_COLS;
    localparam int SCREEN_ROWS = tcs_pkg::SCREEN_ROWS;
    localparam int DEPTH = RING_LINES * SCREEN_COLS;
    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(RING_LINES + 1);
    localparam int CW = $clog2(SCREEN_COLS + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_NL    = 3'd3;
    localparam logic [2:0] S_RD1   = 3'd4;
    localparam logic [2:0] S_RD2   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [LW-1:0] cur_reg, cur_next, used_reg, used_next, back_reg, back_next;
    logic [4:0]  row_reg, row_next;
    logic [6:0]  col_reg, col_next;
    logic [2:0]  tabn_reg, tabn_next;
    logic [CW-1:0] x_reg, x_next;
    logic [7:0]  color_reg;
    logic        gfx_reg;
    logic [4:0]  step_reg;
    tcs_pkg::in_item_t in_reg, in_next;
    tcs_pkg::out_item_t out_reg, out_next;
    logic        ovalid_reg, ovalid_next;
    logic [AW-1:0] base_reg, base_next;
    logic        blank_reg, blank_next;

    logic        we;
    logic [AW-1:0] addr;
    logic [15:0] wdata, rdata;

    tcs_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign in_ch.ready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= 8'd7;
            gfx_reg   <= 1'b0;
            step_reg  <= 5'd5;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcs_pkg::REG_COLOR: color_reg <= cfg_data;
                tcs_pkg::REG_GFX:   gfx_reg   <= cfg_data[0];
                tcs_pkg::REG_STEP:  step_reg  <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    logic [LW-1:0] cur_inc;
    logic [LW+6:0] vis;
    logic [LW+6:0] backv;
    logic [LW:0]   lim, nxt;
    logic [LW:0]   ridx;
    logic [6:0]    colw;

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        cur_next = cur_reg;
        used_next = used_reg;
        back_next = back_reg;
        row_next = row_reg;
        col_next = col_reg;
        tabn_next = tabn_reg;
        x_next = x_reg;
        in_next = in_reg;
        out_next = out_reg;
        ovalid_next = ovalid_reg;
        base_next = base_reg;
        blank_next = blank_reg;
        we = 1'b0;
        addr = clr_reg;
        wdata = tcs_pkg::BLANK_CELL;
        cur_inc = (cur_reg == LW'(RING_LINES - 1)) ? '0 : cur_reg + 1'b1;
        vis = (LW+7)'(row_reg) + (LW+7)'(back_reg);
        backv = vis - (LW+7)'(in_reg.read_row);
        lim = (used_reg > LW'(SCREEN_ROWS)) ? (LW+1)'(used_reg - LW'(SCREEN_ROWS)) : '0;
        nxt = (LW+1)'(back_reg) + (LW+1)'(step_reg);
        ridx = (LW+1)'(cur_reg) + (LW+1)'(RING_LINES) - (LW+1)'(backv);
        if (ridx >= (LW+1)'(RING_LINES))
            ridx = ridx - (LW+1)'(RING_LINES);
        colw = (col_reg >= 7'(SCREEN_COLS)) ? 7'(SCREEN_COLS - 1) : col_reg;

        if (out_ch.ready && ovalid_reg)
            ovalid_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    in_next = in_ch.data;
                    out_next = '0;
                    if (in_ch.data.op == tcs_pkg::OP_READ)
                        state_next = S_RD1;
                    else if (gfx_reg)
                    begin
                        out_next.ignored = 1'b1;
                        state_next = S_OUT;
                    end
                    else if (in_ch.data.op == tcs_pkg::OP_PUT)
                    begin
                        back_next = '0;
                        if (in_ch.data.char_code == tcs_pkg::CH_NL)
                        begin
                            x_next = '0;
                            state_next = S_NL;
                        end
                        else if (in_ch.data.char_code == tcs_pkg::CH_BS)
                        begin
                            if (col_reg != 7'd0)
                                col_next = col_reg - 1'b1;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            tabn_next = (in_ch.data.char_code == tcs_pkg::CH_TAB)
                                ? 3'd4 - {1'b0, col_reg[1:0]} : 3'd1;
                            if (in_ch.data.char_code == tcs_pkg::CH_TAB)
                                in_next.char_code = tcs_pkg::CH_SP;
                            state_next = S_WRITE;
                        end
                    end
                    else if (in_ch.data.op == tcs_pkg::OP_UP)
                    begin
                        back_next = LW'((nxt > lim) ? lim : nxt);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        back_next = (back_reg > LW'(step_reg)) ? back_reg - LW'(step_reg) : '0;
                        state_next = S_OUT;
                    end
                end
            end
            S_WRITE:
            begin
                we = 1'b1;
                addr = AW'(cur_reg * SCREEN_COLS) + AW'(colw);
                wdata = {color_reg, in_reg.char_code};
                tabn_next = tabn_reg - 1'b1;
                if (colw == 7'(SCREEN_COLS - 1))
                begin
                    x_next = '0;
                    state_next = S_NL;
                end
                else
                begin
                    col_next = colw + 1'b1;
                    if (tabn_reg == 3'd1)
                        state_next = S_OUT;
                end
            end
            S_NL:
            begin
                we = 1'b1;
                addr = AW'(cur_inc * SCREEN_COLS) + AW'(x_reg);
                x_next = x_reg + 1'b1;
                if (x_reg == CW'(SCREEN_COLS - 1))
                begin
                    cur_next = cur_inc;
                    col_next = '0;
                    if (row_reg != 5'(SCREEN_ROWS - 1))
                        row_next = row_reg + 1'b1;
                    if (used_reg != LW'(RING_LINES))
                        used_next = used_reg + 1'b1;
                    if (in_reg.char_code != tcs_pkg::CH_NL && tabn_reg != 3'd0)
                        state_next = S_WRITE;
                    else
                        state_next = S_OUT;
                end
            end
            S_RD1:
            begin
                blank_next = (in_reg.read_row >= 5'(SCREEN_ROWS))
                    || (in_reg.read_col >= 7'(SCREEN_COLS))
                    || ((LW+7)'(in_reg.read_row) > vis)
                    || (backv >= (LW+7)'(used_reg));
                base_next = AW'(ridx * SCREEN_COLS) + AW'(in_reg.read_col);
                state_next = S_RD2;
            end
            S_RD2:
            begin
                addr = base_reg;
                state_next = S_OUT;
                in_next.op = tcs_pkg::OP_READ;
                x_next = '0;
            end
            S_OUT:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    if (in_reg.op == tcs_pkg::OP_READ)
                        out_next.cell_res = blank_reg ? tcs_pkg::BLANK_CELL : rdata;
                    out_next.cursor_row = row_reg;
                    out_next.cursor_col = col_reg;
                    out_next.view_offset = 10'(back_reg);
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            cur_reg <= '0;
            used_reg <= LW'(1);
            back_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            cur_reg <= cur_next;
            used_reg <= used_next;
            back_reg <= back_next;
            row_reg <= row_next;
            col_reg <= col_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tabn_reg <= tabn_next;
        x_reg <= x_next;
        in_reg <= in_next;
        out_reg <= out_next;
        base_reg <= base_next;
        blank_reg <= blank_next;
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg != '0 && used_reg <= LW'(RING_LINES))
        else $error("used lines out of range");
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg < 5'(SCREEN_ROWS))
        else $error("cursor row out of range");
    a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !ovalid_reg)
        else $error("result before work");
endmodule

// File: tb/tb_text_console_scrollback.sv
// Testbench for the text console scrollback block with a cell-level scoreboard.
`timescale 1ns / 1ps

class console_scoreboard;
    logic [15:0] cells [0:199][0:79];
    int unsigned cur_line;
    int unsigned used;
    int unsigned back;
    int unsigned row;
    int unsigned col;
    logic [7:0] color;
    logic gfx;
    logic [4:0] step;
    tcs_pkg::out_item_t pending[$];
    int errors;

    function void reset_state();
        foreach (cells[i, j]) cells[i][j] = tcs_pkg::BLANK_CELL;
        cur_line = 0;
        used = 1;
        back = 0;
        row = 0;
        col = 0;
        color = 8'd7;
        gfx = 1'b0;
        step = 5'd5;
        errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
        if (idx == tcs_pkg::REG_COLOR) color = val;
        else if (idx == tcs_pkg::REG_GFX) gfx = val[0];
        else if (idx == tcs_pkg::REG_STEP) step = val[4:0];
    endfunction

    function void new_line();
        col = 0;
        if (row < 24) row++;
        cur_line = (cur_line + 1) % 200;
        for (int x = 0; x < 80; x++) cells[cur_line][x] = tcs_pkg::BLANK_CELL;
        if (used < 200) used++;
    endfunction

    function void put_cell(logic [7:0] ch);
        cells[cur_line][col % 80] = {color, ch};
        col = col % 80 + 1;
        if (col >= 80) new_line();
    endfunction

    function logic [15:0] visible(int unsigned r, int unsigned c);
        int unsigned lines_back;
        if (r >= 25 || c >= 80) return tcs_pkg::BLANK_CELL;
        if (r > row + back) return tcs_pkg::BLANK_CELL;
        lines_back = row + back - r;
        if (lines_back >= used) return tcs_pkg::BLANK_CELL;
        return cells[(cur_line + 200 - lines_back) % 200][c];
    endfunction

    function void note_input(tcs_pkg::in_item_t it);
        tcs_pkg::out_item_t res;
        int unsigned lim;
        int unsigned n;
        res = '0;
        if (it.op == tcs_pkg::OP_READ)
        begin
            res.cell_res = visible(it.read_row, it.read_col);
        end
        else if (gfx)
        begin
            res.ignored = 1'b1;
        end
        else if (it.op == tcs_pkg::OP_PUT)
        begin
            back = 0;
            if (it.char_code == tcs_pkg::CH_NL) new_line();
            else if (it.char_code == tcs_pkg::CH_BS)
            begin
                if (col > 0) col--;
            end
            else if (it.char_code == tcs_pkg::CH_TAB)
            begin
                n = 4 - col % 4;
                for (int i = 0; i < n; i++) put_cell(tcs_pkg::CH_SP);
            end
            else put_cell(it.char_code);
        end
        else if (it.op == tcs_pkg::OP_UP)
        begin
            lim = used > 25 ? used - 25 : 0;
            back = back + step > lim ? lim : back + step;
        end
        else
        begin
            back = back > step ? back - step : 0;
        end
        res.cursor_row = row[4:0];
        res.cursor_col = col[6:0];
        res.view_offset = back[9:0];
        pending.push_back(res);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    task check_result(tcs_pkg::out_item_t got);
        tcs_pkg::out_item_t want;
        if (pending.size() == 0)
        begin
            report("unexpected result", got.cell_res, 0);
            return;
        end
        want = pending.pop_front();
        if (got.cell_res !== want.cell_res) report("cell_res", got.cell_res, want.cell_res);
        if (got.cursor_row !== want.cursor_row)
            report("cursor_row", got.cursor_row, want.cursor_row);
        if (got.cursor_col !== want.cursor_col)
            report("cursor_col", got.cursor_col, want.cursor_col);
        if (got.view_offset !== want.view_offset)
            report("view_offset", got.view_offset, want.view_offset);
        if (got.ignored !== want.ignored) report("ignored", got.ignored, want.ignored);
    endtask
endclass

module tb_text_console_scrollback;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = tcs_pkg::REG_COLOR;
    logic [7:0] cfg_data = '0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int stall_cycles = 0;
    console_scoreboard sb;

    tcs_in_if in_ch();
    tcs_out_if out_ch();

    text_console_scrollback dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (stall_cycles > 100000)
        begin
            $display("text_console_scrollback verification failed");
            $finish;
        end
    end

    task automatic send(input logic [1:0] op, input logic [7:0] ch,
                        input logic [4:0] r, input logic [6:0] c);
        tcs_pkg::in_item_t it;
        it.op = op;
        it.char_code = ch;
        it.read_row = r;
        it.read_col = c;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_input(it);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic random_item();
        int k;
        logic [7:0] ch;
        k = $urandom_range(99);
        if (k < 45)
        begin
            ch = 8'($urandom_range(255));
            case ($urandom_range(9))
                0, 1: ch = tcs_pkg::CH_NL;
                2: ch = tcs_pkg::CH_BS;
                3: ch = tcs_pkg::CH_TAB;
                default: ;
            endcase
            send(tcs_pkg::OP_PUT, ch, '0, '0);
        end
        else if (k < 55)
            send(tcs_pkg::OP_UP, 8'($urandom), 5'($urandom), 7'($urandom));
        else if (k < 63)
            send(tcs_pkg::OP_DOWN, 8'($urandom), 5'($urandom), 7'($urandom));
        else if (k < 93)
            send(tcs_pkg::OP_READ, '0, 5'($urandom_range(24)), 7'($urandom_range(79)));
        else
            send(tcs_pkg::OP_READ, 8'($urandom), 5'($urandom), 7'($urandom));
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(tcs_pkg::REG_COLOR, 8'hff);
        send(tcs_pkg::OP_PUT, 8'h00, '0, '0);
        send(tcs_pkg::OP_PUT, 8'hff, '0, '0);
        send(tcs_pkg::OP_PUT, tcs_pkg::CH_TAB, '0, '0);
        send(tcs_pkg::OP_PUT, tcs_pkg::CH_BS, '0, '0);
        send(tcs_pkg::OP_READ, '0, 5'd0, 7'd0);
        send(tcs_pkg::OP_READ, '0, 5'd0, 7'd1);
        send(tcs_pkg::OP_READ, '0, 5'd31, 7'd127);
        send(tcs_pkg::OP_READ, '0, 5'd24, 7'd79);
        send(tcs_pkg::OP_PUT, tcs_pkg::CH_NL, '0, '0);
        send(tcs_pkg::OP_PUT, tcs_pkg::CH_BS, '0, '0);
        send(tcs_pkg::OP_PUT, tcs_pkg::CH_BS, '0, '0);
        send(tcs_pkg::OP_UP, '0, '0, '0);
        send(tcs_pkg::OP_DOWN, '0, '0, '0);
        for (int i = 0; i < 90; i++) send(tcs_pkg::OP_PUT, tcs_pkg::CH_TAB, '0, '0);
        send(tcs_pkg::OP_UP, '0, '0, '0);
        send(tcs_pkg::OP_READ, '0, 5'd0, 7'd3);
        write_reg(tcs_pkg::REG_GFX, 8'd1);
        send(tcs_pkg::OP_PUT, 8'h41, '0, '0);
        send(tcs_pkg::OP_UP, '0, '0, '0);
        send(tcs_pkg::OP_DOWN, '0, '0, '0);
        send(tcs_pkg::OP_READ, '0, 5'd1, 7'd0);
        write_reg(tcs_pkg::REG_GFX, 8'd0);
        write_reg(tcs_pkg::REG_STEP, 8'd0);
        send(tcs_pkg::OP_UP, '0, '0, '0);

        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = phase == 0 ? 9 : (phase == 1 ? 69 : 0);
            snk_idle_pct = phase == 0 ? 69 : (phase == 1 ? 9 : 0);
            write_reg(tcs_pkg::REG_STEP,
                phase == 0 ? 8'd24 : (phase == 1 ? 8'd1 : 8'($urandom_range(1, 24))));
            write_reg(tcs_pkg::REG_COLOR, phase == 0 ? 8'h00 : 8'($urandom_range(255)));
            for (int i = 0; i < 520; i++)
            begin
                if (i == 260) drain();
                if (i % 130 == 129) write_reg(tcs_pkg::REG_GFX, 8'($urandom_range(3) == 0));
                if (i % 130 == 0) write_reg(tcs_pkg::REG_GFX, 8'd0);
                random_item();
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("text_console_scrollback verification clean");
        else
            $display("text_console_scrollback verification failed");
        $finish;
    end
endmodule
